/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/psfa_pkg.sv */
// ----------------------------------------------------------------------------
// psfa_pkg
// Types and constants for the particle sensor frame averager.
// ----------------------------------------------------------------------------
package psfa_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    // frame byte offsets
    localparam logic [POS_W-1:0] POS_HDR_FIRST  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SUM_START  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_PM25_HI    = POS_W'(6);
    localparam logic [POS_W-1:0] POS_PM25_LO    = POS_W'(7);
    localparam logic [POS_W-1:0] POS_PM10_HI    = POS_W'(8);
    localparam logic [POS_W-1:0] POS_PM10_LO    = POS_W'(9);
    localparam logic [POS_W-1:0] POS_CHK_HI     = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_CHK_LO     = POS_W'(FRAME_BYTES - 1);

    localparam logic [7:0]  HDR_FIRST    = 8'd66;
    localparam logic [7:0]  HDR_SECOND   = 8'd77;
    localparam logic [15:0] HDR_SUM      = 16'd143;
    localparam logic [15:0] LOWEST_START = 16'd20000;
    localparam logic [7:0]  COUNT_MAX    = 8'd255;

    localparam logic [31:0] INTERVAL_RST = 32'd145000;
    localparam logic [15:0] WARMUP_RST   = 16'd15000;
    localparam logic [15:0] READING_RST  = 16'd5000;

    // serial divider widths: dividend is total*200+n, divisor is 2n
    localparam int DIV_DVD_W = 32;
    localparam int DIV_DVS_W = 9;

    typedef enum logic [1:0] {
        CFG_INTERVAL = 2'd0,
        CFG_WARMUP   = 2'd1,
        CFG_READING  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } t_cmd;

endpackage

/* src/psfa_div.sv */
// ----------------------------------------------------------------------------
// psfa_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psfa_div
    import psfa_pkg::*;
#(
    parameter int DVD_W = DIV_DVD_W,
    parameter int DVS_W = DIV_DVS_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dq;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_trial;
    logic             w_ge;
    logic [DVS_W:0]   w_diff;

    assign w_trial = {r_rem, r_dq[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dq  <= {r_dq[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

/* src/particle_sensor_frame_averager.sv */
// ----------------------------------------------------------------------------
// particle_sensor_frame_averager
// Duty-cycles a particulate sensor, parses its 32-byte frames and reports
// trimmed PM2.5 / PM10 means in hundredths on collect.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                   payload
//  s (item)  in   i_s_tvalid / o_s_tready     tdata: rx_byte, time_ms; tuser: kind
//  m (res)   out  o_m_tvalid / i_m_tready     tdata: cmd, acc, bad, pm10, pm25, n
//  cfg       in   i_cfg_we (no wait)          i_cfg_idx, i_cfg_wdata
//
//  Byte beat: accept, window math, compare, then parse and emit; the result
//  is registered from parse and emit, which waits while the output stalls.
//  Collect beat: window math, trim, the PM10 then the PM2.5 divide, emit; the
//  divides are skipped without samples, and share one 32-step serial divider.
//  Input is taken only in idle; a finished result sits in the output register
//  while the next beat is accepted, and a result waits there on a stall.
//  Synchronous active-low reset restores control registers and sensor state.
// ----------------------------------------------------------------------------
module particle_sensor_frame_averager
    import psfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [7:0] rx_byte, [39:8] time_ms
    input  logic        i_s_tuser,   // [0] kind: 0 byte, 1 collect
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [1:0] sensor_command, [2] frame_accepted,
                                     // [3] frame_bad, [26:4] pm10_avg_centi,
                                     // [49:27] pm25_avg_centi, [57:50] samples_used
    output logic        o_m_tuser,   // [0] average_valid
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SPAN = 8'b0000_0010,  // window start from registers
        S_CMP  = 8'b0000_0100,  // time compares
        S_BYTE = 8'b0000_1000,  // parse and emit
        S_TRIM = 8'b0001_0000,  // drop min/max past two samples, clear accumulators
        S_LOAD = 8'b0010_0000,  // start a divide
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    // ---------------- control registers ----------------
    t_state            r_state, n_state;
    logic [31:0]       r_interval, n_interval;
    logic [15:0]       r_warmup, n_warmup;
    logic [15:0]       r_reading, n_reading;
    logic              r_running, n_running;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [15:0]       r_sum, n_sum;
    logic [15:0]       r_sum_exp, n_sum_exp;
    logic [15:0]       r_pm25_fld, n_pm25_fld;
    logic [15:0]       r_pm10_fld, n_pm10_fld;
    logic [23:0]       r_pm10_tot, n_pm10_tot;
    logic [23:0]       r_pm25_tot, n_pm25_tot;
    logic [15:0]       r_pm10_lo, n_pm10_lo;
    logic [15:0]       r_pm10_hi, n_pm10_hi;
    logic [15:0]       r_pm25_lo, n_pm25_lo;
    logic [15:0]       r_pm25_hi, n_pm25_hi;
    logic [7:0]        r_count, n_count;
    logic              r_out_valid, n_out_valid;

    // ---------------- payload registers ----------------
    logic              r_kind, n_kind;
    logic [7:0]        r_byte, n_byte;
    logic [31:0]       r_time, n_time;
    logic [31:0]       r_start, n_start;
    logic              r_over, n_over;
    logic              r_pre, n_pre;
    logic              r_in_read, n_in_read;
    logic [23:0]       r_s10, n_s10;
    logic [23:0]       r_s25, n_s25;
    logic [7:0]        r_n, n_n;
    logic              r_sel, n_sel;
    logic              r_col_stop, n_col_stop;
    logic [22:0]       r_avg10, n_avg10;
    logic [22:0]       r_avg25, n_avg25;
    t_cmd              r_o_cmd, n_o_cmd;
    logic              r_o_acc, n_o_acc;
    logic              r_o_bad, n_o_bad;
    logic              r_o_avgv, n_o_avgv;
    logic [22:0]       r_o_pm10, n_o_pm10;
    logic [22:0]       r_o_pm25, n_o_pm25;
    logic [7:0]        r_o_n, n_o_n;

    // ---------------- combinational helpers ----------------
    logic                 w_in_acc;
    logic                 w_out_free;
    logic [16:0]          w_span;
    logic                 w_hdr_bad;
    logic [15:0]          w_exp_full;
    logic                 w_chk_ok;
    logic [23:0]          w_sel_tot;
    logic [DIV_DVD_W-1:0] w_prod;
    logic [DIV_DVD_W-1:0] w_dvd;
    logic [DIV_DVS_W-1:0] w_dvs;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [DIV_DVD_W-1:0] w_quot;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_span     = {1'b0, r_warmup} + {1'b0, r_reading};
    assign w_hdr_bad  = (r_pos == POS_HDR_FIRST  && r_byte != HDR_FIRST) ||
                        (r_pos == POS_HDR_SECOND && r_byte != HDR_SECOND);
    assign w_exp_full = {r_sum_exp[15:8], r_byte};
    // header bytes are outside the running sum; add their fixed total here
    assign w_chk_ok   = w_exp_full == (r_sum + HDR_SUM);

    // mean in hundredths, half up: (total*200 + n) / (2n)
    assign w_sel_tot   = r_sel ? r_s25 : r_s10;
    assign w_prod      = {8'b0, w_sel_tot} * 32'd200;
    assign w_dvd       = w_prod + {24'b0, r_n};
    assign w_dvs       = {r_n, 1'b0};
    assign w_div_start = r_state == S_LOAD;

    psfa_div #(
        .DVD_W (DIV_DVD_W),
        .DVS_W (DIV_DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_interval  = r_interval;
        n_warmup    = r_warmup;
        n_reading   = r_reading;
        n_running   = r_running;
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_sum_exp   = r_sum_exp;
        n_pm25_fld  = r_pm25_fld;
        n_pm10_fld  = r_pm10_fld;
        n_pm10_tot  = r_pm10_tot;
        n_pm25_tot  = r_pm25_tot;
        n_pm10_lo   = r_pm10_lo;
        n_pm10_hi   = r_pm10_hi;
        n_pm25_lo   = r_pm25_lo;
        n_pm25_hi   = r_pm25_hi;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_m_tready;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_time      = r_time;
        n_start     = r_start;
        n_over      = r_over;
        n_pre       = r_pre;
        n_in_read   = r_in_read;
        n_s10       = r_s10;
        n_s25       = r_s25;
        n_n         = r_n;
        n_sel       = r_sel;
        n_col_stop  = r_col_stop;
        n_avg10     = r_avg10;
        n_avg25     = r_avg25;
        n_o_cmd     = r_o_cmd;
        n_o_acc     = r_o_acc;
        n_o_bad     = r_o_bad;
        n_o_avgv    = r_o_avgv;
        n_o_pm10    = r_o_pm10;
        n_o_pm25    = r_o_pm25;
        n_o_n       = r_o_n;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INTERVAL: n_interval = i_cfg_wdata;
                CFG_WARMUP:   n_warmup   = i_cfg_wdata[15:0];
                CFG_READING:  n_reading  = i_cfg_wdata[15:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_kind  = i_s_tuser;
                    n_byte  = i_s_tdata[7:0];
                    n_time  = i_s_tdata[39:8];
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                // window start clamps at zero on a short interval
                n_over  = r_interval > {15'b0, w_span};
                n_start = n_over ? r_interval - {15'b0, w_span} : '0;
                n_state = r_kind ? S_TRIM : S_CMP;
            end
            S_CMP: begin
                n_pre     = r_time < r_start;
                n_in_read = ({1'b0, r_time} + {17'b0, r_reading}) > {1'b0, r_interval};
                n_state   = S_BYTE;
            end
            S_BYTE: begin
                if (w_out_free) begin
                    n_o_cmd     = CMD_NONE;
                    n_o_acc     = 1'b0;
                    n_o_bad     = 1'b0;
                    n_o_avgv    = 1'b0;
                    n_o_pm10    = '0;
                    n_o_pm25    = '0;
                    n_o_n       = '0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_pre) begin
                        // byte before the window: dropped, sensor held off
                        if (r_running) begin
                            n_running = 1'b0;
                            n_o_cmd   = CMD_STOP;
                        end
                    end else begin
                        if (!r_running) begin
                            n_running = 1'b1;
                            n_o_cmd   = CMD_START;
                        end
                        if (w_hdr_bad) begin
                            n_pos = '0;
                        end else begin
                            if (r_pos == POS_SUM_START) begin
                                n_sum = {8'b0, r_byte};
                            end else if (r_pos > POS_SUM_START && r_pos < POS_CHK_HI) begin
                                n_sum = r_sum + {8'b0, r_byte};
                            end
                            case (r_pos)
                                POS_PM25_HI: n_pm25_fld = {r_byte, 8'h00};
                                POS_PM25_LO: n_pm25_fld = {r_pm25_fld[15:8], r_byte};
                                POS_PM10_HI: n_pm10_fld = {r_byte, 8'h00};
                                POS_PM10_LO: n_pm10_fld = {r_pm10_fld[15:8], r_byte};
                                POS_CHK_HI:  n_sum_exp  = {r_byte, 8'h00};
                                POS_CHK_LO:  n_sum_exp  = w_exp_full;
                                default: ;
                            endcase
                            if (r_pos == POS_CHK_LO) begin
                                if (!w_chk_ok) begin
                                    n_o_bad = 1'b1;
                                end else if (r_in_read && r_count != COUNT_MAX) begin
                                    if (r_count == 8'd0) begin
                                        n_pm10_lo = r_pm10_fld;
                                        n_pm10_hi = r_pm10_fld;
                                        n_pm25_lo = r_pm25_fld;
                                        n_pm25_hi = r_pm25_fld;
                                    end else begin
                                        if (r_pm10_fld < r_pm10_lo) n_pm10_lo = r_pm10_fld;
                                        if (r_pm10_fld > r_pm10_hi) n_pm10_hi = r_pm10_fld;
                                        if (r_pm25_fld < r_pm25_lo) n_pm25_lo = r_pm25_fld;
                                        if (r_pm25_fld > r_pm25_hi) n_pm25_hi = r_pm25_fld;
                                    end
                                    n_pm10_tot = r_pm10_tot + {8'b0, r_pm10_fld};
                                    n_pm25_tot = r_pm25_tot + {8'b0, r_pm25_fld};
                                    n_count    = r_count + 8'd1;
                                    n_o_acc    = 1'b1;
                                end
                                // frame state restarts after every full frame
                                n_pos      = '0;
                                n_sum      = '0;
                                n_pm25_fld = '0;
                                n_pm10_fld = '0;
                            end else begin
                                n_pos = r_pos + POS_W'(1);
                            end
                        end
                    end
                end
            end
            S_TRIM: begin
                if (r_count > 8'd2) begin
                    n_s10 = r_pm10_tot - {8'b0, r_pm10_lo} - {8'b0, r_pm10_hi};
                    n_s25 = r_pm25_tot - {8'b0, r_pm25_lo} - {8'b0, r_pm25_hi};
                    n_n   = r_count - 8'd2;
                end else begin
                    n_s10 = r_pm10_tot;
                    n_s25 = r_pm25_tot;
                    n_n   = r_count;
                end
                n_pm10_tot = '0;
                n_pm25_tot = '0;
                n_pm10_lo  = LOWEST_START;
                n_pm25_lo  = LOWEST_START;
                n_pm10_hi  = '0;
                n_pm25_hi  = '0;
                n_count    = '0;
                n_col_stop = r_over;
                if (r_over) n_running = 1'b0;
                n_sel   = 1'b0;
                n_state = (n_n == 8'd0) ? S_DONE : S_LOAD;
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (!r_sel) begin
                        n_avg10 = w_quot[22:0];
                        n_sel   = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        n_avg25 = w_quot[22:0];
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_o_cmd     = r_col_stop ? CMD_STOP : CMD_NONE;
                    n_o_acc     = 1'b0;
                    n_o_bad     = 1'b0;
                    n_o_avgv    = r_n != 8'd0;
                    n_o_pm10    = (r_n != 8'd0) ? r_avg10 : '0;
                    n_o_pm25    = (r_n != 8'd0) ? r_avg25 : '0;
                    n_o_n       = r_n;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interval  <= INTERVAL_RST;
            r_warmup    <= WARMUP_RST;
            r_reading   <= READING_RST;
            r_running   <= 1'b0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_sum_exp   <= '0;
            r_pm25_fld  <= '0;
            r_pm10_fld  <= '0;
            r_pm10_tot  <= '0;
            r_pm25_tot  <= '0;
            r_pm10_lo   <= LOWEST_START;
            r_pm10_hi   <= '0;
            r_pm25_lo   <= LOWEST_START;
            r_pm25_hi   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_interval  <= n_interval;
            r_warmup    <= n_warmup;
            r_reading   <= n_reading;
            r_running   <= n_running;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_sum_exp   <= n_sum_exp;
            r_pm25_fld  <= n_pm25_fld;
            r_pm10_fld  <= n_pm10_fld;
            r_pm10_tot  <= n_pm10_tot;
            r_pm25_tot  <= n_pm25_tot;
            r_pm10_lo   <= n_pm10_lo;
            r_pm10_hi   <= n_pm10_hi;
            r_pm25_lo   <= n_pm25_lo;
            r_pm25_hi   <= n_pm25_hi;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_byte     <= n_byte;
        r_time     <= n_time;
        r_start    <= n_start;
        r_over     <= n_over;
        r_pre      <= n_pre;
        r_in_read  <= n_in_read;
        r_s10      <= n_s10;
        r_s25      <= n_s25;
        r_n        <= n_n;
        r_sel      <= n_sel;
        r_col_stop <= n_col_stop;
        r_avg10    <= n_avg10;
        r_avg25    <= n_avg25;
        r_o_cmd    <= n_o_cmd;
        r_o_acc    <= n_o_acc;
        r_o_bad    <= n_o_bad;
        r_o_avgv   <= n_o_avgv;
        r_o_pm10   <= n_o_pm10;
        r_o_pm25   <= n_o_pm25;
        r_o_n      <= n_o_n;
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_o_n, r_o_pm25, r_o_pm10, r_o_bad, r_o_acc, r_o_cmd};
    assign o_m_tuser  = r_o_avgv;

endmodule

/* src/psfa_chk.sv */
// ----------------------------------------------------------------------------
// psfa_chk
// Port-level checks for the particle sensor frame averager.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psfa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] i_s_tdata,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_idx,
    input logic [31:0] i_cfg_wdata
);

    logic w_in_beat;
    logic w_unused;

    assign w_in_beat = i_s_tvalid && o_s_tready;
    assign w_unused  = ^{i_s_tdata, i_s_tuser, i_cfg_we, i_cfg_idx, i_cfg_wdata};

    // one beat at a time: busy right after an input beat
    `ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, w_in_beat, !o_s_tready, "ready after beat")

    // no averages or count unless the average is flagged valid
    `ASSERT_SAME(a_avg_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser,
        o_m_tdata[57:4] == 54'd0 || w_unused != w_unused, "average fields without valid")

    // a frame is either accepted or bad, never both
    `ASSERT_SAME(a_acc_bad, i_clk, i_rst_n, o_m_tvalid, !(o_m_tdata[2] && o_m_tdata[3]),
        "frame both accepted and bad")

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")

endmodule

bind particle_sensor_frame_averager psfa_chk u_psfa_chk (.*);

/* verif/particle_sensor_frame_averager_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_sensor_frame_averager_tb
// Drives byte and collect beats through the item stream under random source
// gaps and sink stalls. Predicts every report in a scoreboard class (sensor
// duty cycle, frame parser, PM sums, trimmed means) and compares field by
// field. Walks several register settings, extremes included, and the trim
// boundary at one, two and three samples.
// ----------------------------------------------------------------------------
module particle_sensor_frame_averager_tb;
    import psfa_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int MIX_BEATS    = 110;

    // window edges for the reset settings
    localparam logic [31:0] DFLT_START = INTERVAL_RST - WARMUP_RST - READING_RST;
    localparam logic [31:0] DFLT_READ  = INTERVAL_RST - READING_RST + 32'd1;

    // where in the measurement cycle a byte is stamped
    typedef enum int {
        ZONE_PRE,
        ZONE_WARM,
        ZONE_READ,
        ZONE_ANY
    } t_zone;

    typedef struct {
        logic [1:0]  cmd;
        logic        acc;
        logic        bad;
        logic        avg_ok;
        logic [22:0] pm10;
        logic [22:0] pm25;
        logic [7:0]  n;
    } t_avg_result;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of registers and block state, queue of due reports
    // ------------------------------------------------------------------------
    class pm_report_board;
        logic [31:0] cycle_ms;
        logic [15:0] warm_ms;
        logic [15:0] window_ms;

        bit          sensor_on;
        logic [4:0]  byte_pos;
        logic [15:0] run_sum;
        logic [15:0] frame_sum;
        logic [15:0] pm25_word;
        logic [15:0] pm10_word;
        logic [23:0] pm10_acc;
        logic [23:0] pm25_acc;
        logic [15:0] pm10_lo;
        logic [15:0] pm10_hi;
        logic [15:0] pm25_lo;
        logic [15:0] pm25_hi;
        logic [7:0]  sample_cnt;

        t_avg_result reports_due[$];
        int          errors;
        int          beats_in;
        int          reports_seen;
        int          added;
        int          rejects;
        int          averages;
        int          capped;

        function new();
            cycle_ms  = INTERVAL_RST;
            warm_ms   = WARMUP_RST;
            window_ms = READING_RST;
            sensor_on = 1'b0;
            frame_sum = '0;
            clear_frame();
            clear_sums();
        endfunction

        function void clear_frame();
            byte_pos  = '0;
            run_sum   = '0;
            pm25_word = '0;
            pm10_word = '0;
        endfunction

        function void clear_sums();
            pm10_acc   = '0;
            pm25_acc   = '0;
            pm10_lo    = LOWEST_START;
            pm25_lo    = LOWEST_START;
            pm10_hi    = '0;
            pm25_hi    = '0;
            sample_cnt = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                CFG_INTERVAL: cycle_ms  = value;
                CFG_WARMUP:   warm_ms   = value[15:0];
                CFG_READING:  window_ms = value[15:0];
                default: ;
            endcase
        endfunction

        // hundredths, rounded half up
        function longint unsigned centi_mean(longint unsigned total, longint unsigned cnt);
            return (total * 200 + cnt) / (cnt * 2);
        endfunction

        function int pending();
            return reports_due.size();
        endfunction

        // one accepted beat -> one report
        function void predict_report(bit kind, logic [7:0] rx, logic [31:0] t);
            t_avg_result     r;
            longint unsigned span, start, s10, s25, cnt;
            logic [4:0]      p;
            bit              in_read;

            r = '{default: '0};
            beats_in++;
            span = 64'(warm_ms) + 64'(window_ms);
            if (kind) begin
                s10 = pm10_acc;
                s25 = pm25_acc;
                cnt = sample_cnt;
                // drop min and max once there are enough samples
                if (cnt > 2) begin
                    s10 = s10 - pm10_lo - pm10_hi;
                    s25 = s25 - pm25_lo - pm25_hi;
                    cnt = cnt - 2;
                end
                if (cnt > 0) begin
                    r.avg_ok = 1'b1;
                    r.pm10   = 23'(centi_mean(s10, cnt));
                    r.pm25   = 23'(centi_mean(s25, cnt));
                    r.n      = 8'(cnt);
                    averages++;
                end
                clear_sums();
                if (64'(cycle_ms) > span) begin
                    sensor_on = 1'b0;
                    r.cmd     = CMD_STOP;
                end
            end else begin
                // window start clamps at zero on a short interval
                start = (64'(cycle_ms) > span) ? 64'(cycle_ms) - span : 64'd0;
                if (64'(t) < start) begin
                    if (sensor_on) begin
                        sensor_on = 1'b0;
                        r.cmd     = CMD_STOP;
                    end
                end else begin
                    p = byte_pos;
                    if (!sensor_on) begin
                        sensor_on = 1'b1;
                        r.cmd     = CMD_START;
                    end
                    // a header miss is folded into the last slot, which rewinds
                    if (p == POS_HDR_FIRST && rx != HDR_FIRST)        p = POS_CHK_LO;
                    else if (p == POS_HDR_SECOND && rx != HDR_SECOND) p = POS_CHK_LO;
                    else if (p == POS_SUM_START) run_sum         = 16'(rx);
                    else if (p == POS_PM25_HI)   pm25_word       = {rx, 8'h00};
                    else if (p == POS_PM25_LO)   pm25_word[7:0]  = rx;
                    else if (p == POS_PM10_HI)   pm10_word       = {rx, 8'h00};
                    else if (p == POS_PM10_LO)   pm10_word[7:0]  = rx;
                    else if (p == POS_CHK_HI)    frame_sum       = {rx, 8'h00};
                    else if (p == POS_CHK_LO)    frame_sum[7:0]  = rx;

                    if (p > POS_SUM_START && p < POS_CHK_HI)
                        run_sum = run_sum + 16'(rx);

                    if (p == POS_CHK_LO && byte_pos == POS_CHK_LO) begin
                        in_read = (64'(t) + 64'(window_ms)) > 64'(cycle_ms);
                        if (frame_sum != 16'(run_sum + HDR_SUM)) begin
                            r.bad = 1'b1;
                            rejects++;
                        end else if (in_read && sample_cnt == COUNT_MAX) begin
                            capped++;
                        end else if (in_read) begin
                            if (sample_cnt == 0) begin
                                pm10_lo = pm10_word;
                                pm10_hi = pm10_word;
                                pm25_lo = pm25_word;
                                pm25_hi = pm25_word;
                            end else begin
                                if (pm10_word < pm10_lo) pm10_lo = pm10_word;
                                if (pm10_word > pm10_hi) pm10_hi = pm10_word;
                                if (pm25_word < pm25_lo) pm25_lo = pm25_word;
                                if (pm25_word > pm25_hi) pm25_hi = pm25_word;
                            end
                            pm10_acc   = pm10_acc + 24'(pm10_word);
                            pm25_acc   = pm25_acc + 24'(pm25_word);
                            sample_cnt = sample_cnt + 8'd1;
                            r.acc      = 1'b1;
                            added++;
                        end
                        clear_frame();
                    end else if (p == POS_CHK_LO) begin
                        byte_pos = '0;
                    end else begin
                        byte_pos = p + 5'd1;
                    end
                end
            end
            reports_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [22:0] want, logic [22:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(t_avg_result got);
            t_avg_result want;
            reports_seen++;
            if (reports_due.size() == 0) begin
                $error("report with nothing outstanding");
                errors++;
                return;
            end
            want = reports_due.pop_front();
            compare_field("sensor_command", 23'(want.cmd),    23'(got.cmd));
            compare_field("frame_accepted", 23'(want.acc),    23'(got.acc));
            compare_field("frame_bad",      23'(want.bad),    23'(got.bad));
            compare_field("average_valid",  23'(want.avg_ok), 23'(got.avg_ok));
            compare_field("pm10_avg_centi", want.pm10,        got.pm10);
            compare_field("pm25_avg_centi", want.pm25,        got.pm25);
            compare_field("samples_used",   23'(want.n),      23'(got.n));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its drive
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata   = '0;   // [7:0] rx_byte, [39:8] time_ms
    logic        i_s_tuser   = 1'b0; // [0] kind
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [63:0] o_m_tdata;          // [1:0] cmd, [2] acc, [3] bad, [26:4] pm10,
                                     // [49:27] pm25, [57:50] samples_used
    logic        o_m_tuser;          // [0] average_valid
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = CFG_INTERVAL;
    logic [31:0] i_cfg_wdata = '0;

    pm_report_board sb = new();

    bit          quiet_src  = 1'b0;  // no source gaps
    bit          quiet_sink = 1'b0;  // sink never stalls
    int          stall_left = 0;
    int          sink_roll;
    int          cycle_count = 0;
    int          settings_used = 1;
    t_avg_result seen_report;

    particle_sensor_frame_averager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // sink side: mostly ready, short stalls, the odd long one
    always @(posedge i_clk) begin
        if (quiet_sink) begin
            i_m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 70) begin
                i_m_tready <= 1'b1;
            end else if (sink_roll < 95) begin
                i_m_tready <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end else begin
                i_m_tready <= 1'b0;
                stall_left <= $urandom_range(15, 60);
            end
        end
    end

    // report monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_report.cmd    = o_m_tdata[1:0];
            seen_report.acc    = o_m_tdata[2];
            seen_report.bad    = o_m_tdata[3];
            seen_report.pm10   = o_m_tdata[26:4];
            seen_report.pm25   = o_m_tdata[49:27];
            seen_report.n      = o_m_tdata[57:50];
            seen_report.avg_ok = o_m_tuser;
            sb.check_report(seen_report);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // time stamp inside the requested part of the current cycle
    function automatic logic [31:0] pick_time(t_zone zone);
        longint unsigned iv, rd, span, start, read_lo, hi;
        iv      = sb.cycle_ms;
        rd      = sb.window_ms;
        span    = 64'(sb.warm_ms) + rd;
        start   = (iv > span) ? iv - span : 64'd0;
        read_lo = (iv + 1 > rd) ? iv + 1 - rd : 64'd0;
        if (zone == ZONE_PRE && start > 0)
            return $urandom_range(32'(start - 1), 0);
        if (zone == ZONE_PRE || zone == ZONE_ANY)
            return $urandom;
        if (zone == ZONE_WARM && read_lo > start) begin
            if ($urandom_range(0, 9) == 0) return 32'(read_lo - 1);  // last ms before window
            return $urandom_range(32'(read_lo - 1), 32'(start));
        end
        // reading window, also taken when warm-up is empty
        if (read_lo <= 64'hFFFF_FFFF) begin
            if ($urandom_range(0, 9) == 0) return 32'(read_lo);      // first ms in window
            hi = read_lo + 3000;
            if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
            return $urandom_range(32'(hi), 32'(read_lo));
        end
        return $urandom_range(32'hFFFF_FFFF, 32'(start));
    endfunction

    function automatic logic [15:0] pm_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return 16'($urandom_range(0, 60));
        if (roll < 35) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    // one beat; called on a clock edge, returns on the accepting edge
    task automatic send_beat(input bit kind, input logic [7:0] rx, input logic [31:0] t);
        int gap;
        int roll;
        gap = 0;
        if (!quiet_src) begin
            roll = $urandom_range(0, 99);
            if (roll >= 90)      gap = $urandom_range(8, 40);
            else if (roll >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {t, rx};
        do @(posedge i_clk); while (!o_s_tready);
        sb.predict_report(kind, rx, t);
    endtask

    task automatic send_collect();
        send_beat(1'b1, 8'($urandom), $urandom);
    endtask

    // frame of len bytes; corrupt spoils the checksum
    task automatic send_frame(input t_zone zone, input bit corrupt, input int len);
        logic [7:0]  frame_bytes [FRAME_BYTES];
        logic [15:0] pm25;
        logic [15:0] pm10;
        logic [15:0] sum;
        // walk the parser back to the header first (zeros never start a frame)
        while (sb.byte_pos != 0)
            send_beat(1'b0, 8'h00, pick_time(ZONE_WARM));
        pm25 = pm_value();
        pm10 = pm_value();
        frame_bytes[0] = HDR_FIRST;
        frame_bytes[1] = HDR_SECOND;
        for (int i = 2; i < FRAME_BYTES - 2; i++)
            frame_bytes[i] = 8'($urandom);
        frame_bytes[POS_PM25_HI] = pm25[15:8];
        frame_bytes[POS_PM25_LO] = pm25[7:0];
        frame_bytes[POS_PM10_HI] = pm10[15:8];
        frame_bytes[POS_PM10_LO] = pm10[7:0];
        sum = HDR_SUM;
        for (int i = 2; i < FRAME_BYTES - 2; i++)
            sum = sum + 16'(frame_bytes[i]);
        if (corrupt)
            sum = sum ^ 16'($urandom_range(1, 65535));
        frame_bytes[POS_CHK_HI] = sum[15:8];
        frame_bytes[POS_CHK_LO] = sum[7:0];
        for (int i = 0; i < len; i++)
            send_beat(1'b0, frame_bytes[i], pick_time(zone));
    endtask

    // clean frames in the window most often, also noise, broken frames and collects
    task automatic run_mix(input int budget);
        int first;
        int roll;
        first = sb.beats_in;
        while (sb.beats_in - first < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                send_frame(ZONE_READ, 1'b0, FRAME_BYTES);
            else if (roll < 53)
                send_frame(ZONE_WARM, 1'b0, FRAME_BYTES);
            else if (roll < 60)
                send_frame(ZONE_READ, 1'b1, FRAME_BYTES);
            else if (roll < 68)
                repeat ($urandom_range(1, 4)) send_beat(1'b0, 8'($urandom), pick_time(ZONE_PRE));
            else if (roll < 75)
                repeat ($urandom_range(1, 6)) send_beat(1'b0, 8'($urandom), pick_time(ZONE_ANY));
            else if (roll < 84)
                send_frame(ZONE_READ, 1'($urandom_range(0, 1)), $urandom_range(1, FRAME_BYTES - 1));
            else
                send_collect();
        end
    endtask

    // idle the block, rewrite all three registers, pick new pacing
    task automatic new_phase(input logic [31:0] iv, input logic [15:0] wu, input logic [15:0] rd);
        logic [31:0] word;
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_INTERVAL;
        i_cfg_wdata <= iv;
        @(posedge i_clk);
        sb.write_reg(CFG_INTERVAL, iv);
        word = {16'($urandom), wu};   // upper bits are don't-care
        i_cfg_idx   <= CFG_WARMUP;
        i_cfg_wdata <= word;
        @(posedge i_clk);
        sb.write_reg(CFG_WARMUP, word);
        word = {16'($urandom), rd};
        i_cfg_idx   <= CFG_READING;
        i_cfg_wdata <= word;
        @(posedge i_clk);
        sb.write_reg(CFG_READING, word);
        i_cfg_we   <= 1'b0;
        quiet_src  = ($urandom_range(0, 3) == 0);
        quiet_sink = ($urandom_range(0, 3) == 0);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset settings
        send_beat(1'b0, 8'h00, 32'd0);                 // before window, sensor idle
        send_beat(1'b1, 8'hFF, 32'hFFFF_FFFF);         // collect, nothing gathered
        send_beat(1'b0, 8'hFF, 32'hFFFF_FFFF);         // start, header miss
        send_beat(1'b0, HDR_FIRST, DFLT_START - 1);    // dropped, sensor stopped
        send_beat(1'b0, HDR_FIRST, DFLT_START);        // start on the first ms
        send_beat(1'b0, 8'h00, DFLT_START);            // second header byte wrong
        send_beat(1'b0, HDR_SECOND, DFLT_READ - 1);    // second header byte first
        send_beat(1'b0, HDR_FIRST, DFLT_READ - 1);
        send_beat(1'b0, HDR_SECOND, DFLT_READ);
        send_beat(1'b1, 8'h00, 32'd0);                 // collect leaves parser alone
        send_beat(1'b0, 8'h80, DFLT_READ);             // restart, lands at byte 2
        run_mix(MIX_BEATS);

        new_phase(32'd0, 16'd0, 16'd0);
        run_mix(MIX_BEATS);
        new_phase(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        run_mix(MIX_BEATS);
        new_phase(32'd1000, 16'hFFFF, 16'd100);        // span exceeds interval
        run_mix(MIX_BEATS);
        new_phase(32'd70000, 16'd0, 16'hFFFF);
        run_mix(MIX_BEATS);
        repeat (2) begin
            new_phase($urandom_range(1000, 200000), 16'($urandom_range(0, 5000)),
                      16'($urandom_range(1, 5000)));
            run_mix(MIX_BEATS);
        end

        // trim boundary: one, two and three samples
        new_phase(INTERVAL_RST, WARMUP_RST, READING_RST);
        send_collect();
        for (int k = 1; k <= 3; k++) begin
            repeat (k) send_frame(ZONE_READ, 1'b0, FRAME_BYTES);
            send_collect();
        end

        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d beats over %0d register settings, %0d reports checked.",
                 sb.beats_in, settings_used, sb.reports_seen);
        $display("Frames summed %0d, checksum rejects %0d, averages %0d, frames past cap %0d.",
                 sb.added, sb.rejects, sb.averages, sb.capped);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/psfa_pkg.sv
src/psfa_div.sv
src/particle_sensor_frame_averager.sv
src/psfa_chk.sv
verif/particle_sensor_frame_averager_tb.sv
